// File: rtl/cabn_pkg.sv
// Shared constants and types for the class-aware box suppression block.
// Used by cabn_iou_unit and class_aware_box_nms_top; no dependencies.
`default_nettype none

package cabn_pkg;

   // Kept list sizing
   localparam int MAX_KEPT = 64;
   localparam int IDX_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W    = $clog2(MAX_KEPT + 1);
   localparam int TOTAL_W  = 7;

   // Geometry and arithmetic widths
   localparam int COORD_W  = 16;
   localparam int EXTENT_W = 15;
   localparam int CLASS_W  = 7;
   localparam int THR_W    = 16;
   localparam int AREA_W   = 32;
   localparam int PROD_W   = THR_W + AREA_W;
   localparam logic [15:0] ONE_PIXEL = 16'd16;

   // Configuration space
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_IOU_THR = 2'd0;
   localparam logic [THR_W-1:0] IOU_THR_RESET = 16'd29491;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic [EXTENT_W-1:0]       width;
      logic [EXTENT_W-1:0]       height;
   } box_type;

   // One kept list entry: geometry, class and precomputed inclusive area
   typedef struct packed {
      box_type             box;
      logic [CLASS_W-1:0]  cls;
      logic [AREA_W-1:0]   area;
   } entry_type;

   // Status from the overlap unit back to the sequencer
   typedef struct packed {
      logic busy;
      logic hit;
   } iou_status_type;

endpackage

`default_nettype wire

// File: rtl/class_aware_box_nms_top.sv
// Top level of the class-aware greedy box suppression block: sequencer,
// kept list memory, CSR port and result register. Depends on cabn_pkg
// and cabn_iou_unit.
//
//   channel   direction  handshake          payload
//   req_      in         req_valid/stall    first_of_set, box, category
//   rsp_      out        rsp_valid/stall    keep, list_overflow, kept_total
//   csr_      in/out     APB psel/penable   iou_threshold at address 0
//
// The kept list memory is read one entry per cycle into the pipelined
// overlap unit, followed by a drain of its five stages.
// req_stall is high while a box is being worked on; the next box is taken
// while the previous result still waits in the output register.
// Reset (synchronous) empties the kept list and restores the threshold.
`default_nettype none

module class_aware_box_nms_top (
   input  logic                          clock,
   input  logic                          reset,
   // input boxes
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_first_of_set,
   input  logic signed [15:0]            req_box_left,
   input  logic signed [15:0]            req_box_top,
   input  logic [14:0]                   req_box_width,
   input  logic [14:0]                   req_box_height,
   input  logic [6:0]                    req_category,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_keep,
   output logic                          rsp_list_overflow,
   output logic [6:0]                    rsp_kept_total,
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cabn_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import cabn_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type          state_ff;
   box_type            box_ff;
   logic [CLASS_W-1:0] cls_ff;
   logic               first_ff;
   logic [AREA_W-1:0]  area_ff;
   logic [THR_W-1:0]   thr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               ovf_ff;
   logic [CNT_W-1:0]   rd_idx_ff;
   logic               rd_valid_ff;
   entry_type          rd_data_ff;
   logic               suppress_ff;
   logic               rsp_valid_ff;
   logic               rsp_keep_ff;
   logic               rsp_ovf_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;

   entry_type          kept_mem [MAX_KEPT];

   logic               csr_wr;
   logic               out_free;
   logic               rd_en;
   logic               has_room;
   logic               mem_we;
   logic [AREA_W-1:0]  new_area;
   entry_type          new_entry;
   iou_status_type     iou_status;

   // CSR access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr == CSR_ADDR_IOU_THR) ? {16'h0000, thr_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= IOU_THR_RESET;
      end else if (csr_wr && csr_paddr == CSR_ADDR_IOU_THR) begin
         thr_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   // Sequencer controls
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_en     = (state_ff == ST_SCAN) && (rd_idx_ff < count_ff);
   assign has_room  = (count_ff < CNT_W'(MAX_KEPT));
   assign mem_we    = (state_ff == ST_DONE) && out_free && !suppress_ff && has_room;
   assign new_area  = AREA_W'({1'b0, box_ff.width} + ONE_PIXEL) *
                      AREA_W'({1'b0, box_ff.height} + ONE_PIXEL);

   always_comb begin
      new_entry.box  = box_ff;
      new_entry.cls  = cls_ff;
      new_entry.area = area_ff;
   end

   // Kept list memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         kept_mem[count_ff[IDX_W-1:0]] <= new_entry;
      end
      if (rd_en) begin
         rd_data_ff <= kept_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // Overlap test, fed only with entries of the same class
   cabn_iou_unit u_iou (
      .clock    (clock),
      .reset    (reset),
      .op_valid (rd_valid_ff && (rd_data_ff.cls == cls_ff)),
      .box_a    (rd_data_ff.box),
      .area_a   (rd_data_ff.area),
      .box_b    (box_ff),
      .area_b   (area_ff),
      .thr      (thr_ff),
      .status   (iou_status)
   );

   // State, list bookkeeping and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rd_idx_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         suppress_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished result, drop the result once taken
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // clear hits for a new box, collect hits from the overlap unit
         if (state_ff == ST_PREP) begin
            suppress_ff <= 1'b0;
         end else if (iou_status.hit) begin
            suppress_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  box_ff.left   <= req_box_left;
                  box_ff.top    <= req_box_top;
                  box_ff.width  <= req_box_width;
                  box_ff.height <= req_box_height;
                  cls_ff        <= req_category;
                  first_ff      <= req_first_of_set;
                  state_ff      <= ST_PREP;
               end
            end
            ST_PREP: begin
               if (first_ff) begin
                  count_ff <= '0;
                  ovf_ff   <= 1'b0;
               end
               area_ff     <= new_area;
               rd_idx_ff   <= '0;
               state_ff    <= ST_SCAN;
            end
            ST_SCAN: begin
               // advance one entry per cycle
               rd_valid_ff <= rd_en;
               if (rd_en) begin
                  rd_idx_ff <= rd_idx_ff + 1'b1;
               end else begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!rd_valid_ff && !iou_status.busy) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_keep_ff  <= !suppress_ff;
                  if (!suppress_ff && has_room) begin
                     count_ff     <= count_ff + 1'b1;
                     rsp_total_ff <= TOTAL_W'(count_ff + 1'b1);
                     rsp_ovf_ff   <= ovf_ff;
                  end else if (!suppress_ff) begin
                     ovf_ff       <= 1'b1;
                     rsp_total_ff <= TOTAL_W'(count_ff);
                     rsp_ovf_ff   <= 1'b1;
                  end else begin
                     rsp_total_ff <= TOTAL_W'(count_ff);
                     rsp_ovf_ff   <= ovf_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_keep          = rsp_keep_ff;
   assign rsp_list_overflow = rsp_ovf_ff;
   assign rsp_kept_total    = rsp_total_ff;

endmodule

`default_nettype wire

// File: rtl/cabn_iou_unit.sv
// Pipelined overlap test: decides whether the IoU of two boxes exceeds
// the Q0.16 threshold, one box pair per cycle. Depends on cabn_pkg.
`default_nettype none

module cabn_iou_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     op_valid,
   input  cabn_pkg::box_type        box_a,
   input  logic [cabn_pkg::AREA_W-1:0] area_a,
   input  cabn_pkg::box_type        box_b,
   input  logic [cabn_pkg::AREA_W-1:0] area_b,
   input  logic [cabn_pkg::THR_W-1:0]  thr,
   output cabn_pkg::iou_status_type status
);
   import cabn_pkg::*;

   // Stage 1 combinational: overlap extents
   logic signed [17:0] ra, rb, ba, bb, la, lb, ta, tb;
   logic signed [17:0] min_r, max_l, min_b, max_t, iw_s, ih_s;

   // Pipeline registers
   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [15:0]       iw1_ff, ih1_ff;
   logic [AREA_W-1:0] asum1_ff, asum2_ff;
   logic [AREA_W-1:0] inter2_ff, inter3_ff, inter4_ff;
   logic [AREA_W-1:0] uni3_ff;
   logic              nz4_ff;
   logic [PROD_W-1:0] prod4_ff;
   logic              hit5_ff;

   always_comb begin
      la = $signed({{2{box_a.left[15]}}, box_a.left});
      lb = $signed({{2{box_b.left[15]}}, box_b.left});
      ta = $signed({{2{box_a.top[15]}}, box_a.top});
      tb = $signed({{2{box_b.top[15]}}, box_b.top});
      ra = la + $signed({3'b000, box_a.width});
      rb = lb + $signed({3'b000, box_b.width});
      ba = ta + $signed({3'b000, box_a.height});
      bb = tb + $signed({3'b000, box_b.height});
      min_r = (ra < rb) ? ra : rb;
      max_l = (la > lb) ? la : lb;
      min_b = (ba < bb) ? ba : bb;
      max_t = (ta > tb) ? ta : tb;
      iw_s = min_r - max_l + $signed({2'b00, ONE_PIXEL});
      ih_s = min_b - max_t + $signed({2'b00, ONE_PIXEL});
   end

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= op_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Datapath: clamp, intersect area, union, threshold product, compare
   always_ff @(posedge clock) begin
      iw1_ff   <= iw_s[17] ? 16'd0 : iw_s[15:0];
      ih1_ff   <= ih_s[17] ? 16'd0 : ih_s[15:0];
      asum1_ff <= area_a + area_b;

      inter2_ff <= AREA_W'(iw1_ff) * AREA_W'(ih1_ff);
      asum2_ff  <= asum1_ff;

      uni3_ff   <= asum2_ff - inter2_ff;
      inter3_ff <= inter2_ff;

      prod4_ff  <= PROD_W'(thr) * PROD_W'(uni3_ff);
      inter4_ff <= inter3_ff;
      nz4_ff    <= (uni3_ff != '0);

      hit5_ff <= v4_ff && nz4_ff && ({inter4_ff, 16'h0000} > prod4_ff);
   end

   assign status.busy = v1_ff | v2_ff | v3_ff | v4_ff | v5_ff;
   assign status.hit  = v5_ff & hit5_ff;

endmodule

`default_nettype wire
